FILE: src/pcds_pkg.sv
// Shared types, sizes and codes of the point cloud corner-average downsampler.
`default_nettype none
package pcds_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_BLOCKS_PER_ROW = 512;

  localparam int DIM_W = $clog2(MAX_WIDTH) + 1;
  localparam int POS_W = $clog2(MAX_WIDTH);
  localparam int BLK_W = $clog2(MAX_BLOCKS_PER_ROW);
  localparam int NBLK_W = BLK_W + 1;
  localparam int STR_W = 5;
  localparam int PH_W = 4;
  localparam int COORD_W = 32;
  localparam int SUM_W = COORD_W + 2;
  localparam int CHAN_W = 8;
  localparam int CFIELD_W = CHAN_W + 2;
  localparam int CSUM_W = 3 * CFIELD_W;
  localparam int CNT_W = $clog2(DIM_W);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [DIM_W-1:0] MIN_DIM = DIM_W'(2);
  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);
  localparam logic [STR_W-1:0] MIN_STRIDE = STR_W'(2);
  localparam logic [STR_W-1:0] MAX_STRIDE = STR_W'(16);

  localparam logic [DIM_W-1:0] RESET_WIDTH = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);
  localparam logic [STR_W-1:0] RESET_STRIDE = STR_W'(4);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_Y = 2'd3;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DONE,
    ST_IDLE
  } geom_state_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_z;
    logic [CSUM_W-1:0] csum;
    logic [2:0] ok;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic signed [COORD_W-1:0] x_avg;
    logic signed [COORD_W-1:0] y_avg;
    logic signed [COORD_W-1:0] z_avg;
    logic [2:0] ok;
    logic [CHAN_W-1:0] chan0_avg;
    logic [CHAN_W-1:0] chan1_avg;
    logic [CHAN_W-1:0] chan2_avg;
    logic frame_last;
  } result_t;

endpackage
`default_nettype wire

FILE: src/point_cloud_corner_average_downsampler.sv
// Top level of the organized point cloud corner-average downsampler.
`default_nettype none
// Points are taken one per cycle in raster order while in_stall is low, and a block's averaged
// point passes the corner stage register and then the output register (or the skid entry) once
// its bottom-right corner is accepted. Per block column, the corner sums live in one 512-entry
// memory that is read when a corner point is accepted and written back on the next cycle, with
// the last write forwarded when consecutive corners hit the same column. After reset and after
// every configuration write, the input stalls while a shift-subtract divider, one quotient bit
// per cycle, recomputes the block position and the number of blocks per row and per column. The
// output has a two-entry buffer; input stalls while the output is stalled or the skid is full.
module point_cloud_corner_average_downsampler (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [pcds_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  wire logic [pcds_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [pcds_pkg::COORD_W-1:0]   in_x_in,
  input  wire logic signed [pcds_pkg::COORD_W-1:0]   in_y_in,
  input  wire logic signed [pcds_pkg::COORD_W-1:0]   in_z_in,
  input  wire logic                                  in_x_ok,
  input  wire logic                                  in_y_ok,
  input  wire logic                                  in_z_ok,
  input  wire logic [pcds_pkg::CHAN_W-1:0]           in_chan0_in,
  input  wire logic [pcds_pkg::CHAN_W-1:0]           in_chan1_in,
  input  wire logic [pcds_pkg::CHAN_W-1:0]           in_chan2_in,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [pcds_pkg::COORD_W-1:0]        out_x_avg,
  output logic signed [pcds_pkg::COORD_W-1:0]        out_y_avg,
  output logic signed [pcds_pkg::COORD_W-1:0]        out_z_avg,
  output logic                                       out_x_avg_ok,
  output logic                                       out_y_avg_ok,
  output logic                                       out_z_avg_ok,
  output logic [pcds_pkg::CHAN_W-1:0]                out_chan0_avg,
  output logic [pcds_pkg::CHAN_W-1:0]                out_chan1_avg,
  output logic [pcds_pkg::CHAN_W-1:0]                out_chan2_avg,
  output logic                                       out_frame_last
);

  logic [pcds_pkg::DIM_W-1:0] frame_width_r, frame_height_r;
  logic [pcds_pkg::STR_W-1:0] stride_x_r, stride_y_r;
  logic [pcds_pkg::DIM_W-1:0] w_eff, h_eff;
  logic [pcds_pkg::STR_W-1:0] sx_eff, sy_eff, sxm1, sym1;

  pcds_pkg::geom_state_t state_r, state_nxt;
  logic [pcds_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic [pcds_pkg::DIM_W-1:0] col_q, row_q, w_q, h_q;
  logic [pcds_pkg::PH_W-1:0]  col_rem, row_rem, w_rem, h_rem;
  logic div_load, div_step;

  logic [pcds_pkg::POS_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [pcds_pkg::PH_W-1:0]   cx_r, cx_nxt, cy_r, cy_nxt;
  logic [pcds_pkg::BLK_W-1:0]  bx_r, bx_nxt, by_r, by_nxt;
  logic [pcds_pkg::NBLK_W-1:0] nbx_r, nbx_nxt, nby_r, nby_nxt;

  logic in_acc;
  logic cx_first, cx_last, cy_first, cy_last, in_grid, hit, flast;
  pcds_pkg::entry_t pt;

  logic s1_vld_r, s1_first_r, s1_last_r, s1_flast_r;
  logic [pcds_pkg::BLK_W-1:0] s1_addr_r;
  pcds_pkg::entry_t s1_pt_r;

  logic [pcds_pkg::ENTRY_W-1:0] ram_rdata;
  pcds_pkg::entry_t base, upd;
  logic fwd_vld_r;
  logic [pcds_pkg::BLK_W-1:0] fwd_addr_r;
  pcds_pkg::entry_t fwd_data_r;

  pcds_pkg::result_t res, out_r, skid_r;
  logic out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;
  logic s1_res, out_free, out_ld_skid, out_ld_s1, skid_ld;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= pcds_pkg::RESET_WIDTH;
      frame_height_r <= pcds_pkg::RESET_HEIGHT;
      stride_x_r <= pcds_pkg::RESET_STRIDE;
      stride_y_r <= pcds_pkg::RESET_STRIDE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pcds_pkg::CFG_FRAME_WIDTH: frame_width_r <= cfg_wdata;
        pcds_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        pcds_pkg::CFG_STRIDE_X: stride_x_r <= cfg_wdata[pcds_pkg::STR_W-1:0];
        pcds_pkg::CFG_STRIDE_Y: stride_y_r <= cfg_wdata[pcds_pkg::STR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_r < pcds_pkg::MIN_DIM) w_eff = pcds_pkg::MIN_DIM;
    else if (frame_width_r > pcds_pkg::MAX_W_DIM) w_eff = pcds_pkg::MAX_W_DIM;
    else w_eff = frame_width_r;
    if (frame_height_r < pcds_pkg::MIN_DIM) h_eff = pcds_pkg::MIN_DIM;
    else if (frame_height_r > pcds_pkg::MAX_H_DIM) h_eff = pcds_pkg::MAX_H_DIM;
    else h_eff = frame_height_r;
    if (stride_x_r < pcds_pkg::MIN_STRIDE) sx_eff = pcds_pkg::MIN_STRIDE;
    else if (stride_x_r > pcds_pkg::MAX_STRIDE) sx_eff = pcds_pkg::MAX_STRIDE;
    else sx_eff = stride_x_r;
    if (stride_y_r < pcds_pkg::MIN_STRIDE) sy_eff = pcds_pkg::MIN_STRIDE;
    else if (stride_y_r > pcds_pkg::MAX_STRIDE) sy_eff = pcds_pkg::MAX_STRIDE;
    else sy_eff = stride_y_r;
    sxm1 = sx_eff - pcds_pkg::STR_W'(1);
    sym1 = sy_eff - pcds_pkg::STR_W'(1);
  end

  // Geometry recompute sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcds_pkg::ST_LOAD;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    div_load = 1'b0;
    div_step = 1'b0;
    unique case (state_r)
      pcds_pkg::ST_LOAD: begin
        div_load = 1'b1;
        cnt_nxt = '0;
        state_nxt = pcds_pkg::ST_RUN;
      end
      pcds_pkg::ST_RUN: begin
        div_step = 1'b1;
        cnt_nxt = cnt_r + pcds_pkg::CNT_W'(1);
        if (cnt_r == pcds_pkg::CNT_W'(pcds_pkg::DIM_W - 1)) begin
          state_nxt = pcds_pkg::ST_DONE;
        end
      end
      pcds_pkg::ST_DONE: begin
        state_nxt = pcds_pkg::ST_IDLE;
      end
      pcds_pkg::ST_IDLE: begin
        state_nxt = pcds_pkg::ST_IDLE;
      end
      default: state_nxt = pcds_pkg::ST_LOAD;
    endcase
    if (cfg_we) begin
      state_nxt = pcds_pkg::ST_LOAD;
    end
  end

  pcds_div u_div_col (
    .clk(clk), .load(div_load), .step(div_step),
    .dividend({1'b0, col_r}), .divisor(sx_eff), .quot(col_q), .rem(col_rem)
  );

  pcds_div u_div_row (
    .clk(clk), .load(div_load), .step(div_step),
    .dividend({1'b0, row_r}), .divisor(sy_eff), .quot(row_q), .rem(row_rem)
  );

  pcds_div u_div_w (
    .clk(clk), .load(div_load), .step(div_step),
    .dividend(w_eff), .divisor(sx_eff), .quot(w_q), .rem(w_rem)
  );

  pcds_div u_div_h (
    .clk(clk), .load(div_load), .step(div_step),
    .dividend(h_eff), .divisor(sy_eff), .quot(h_q), .rem(h_rem)
  );

  // Position counters.
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    bx_nxt = bx_r;
    by_nxt = by_r;
    nbx_nxt = nbx_r;
    nby_nxt = nby_r;
    if (state_r == pcds_pkg::ST_DONE) begin
      cx_nxt = col_rem;
      bx_nxt = col_q[pcds_pkg::BLK_W-1:0];
      cy_nxt = row_rem;
      by_nxt = row_q[pcds_pkg::BLK_W-1:0];
      nbx_nxt = w_q[pcds_pkg::NBLK_W-1:0];
      nby_nxt = h_q[pcds_pkg::NBLK_W-1:0];
    end else if (in_acc) begin
      if (({1'b0, col_r} + pcds_pkg::DIM_W'(1)) >= w_eff) begin
        col_nxt = '0;
        cx_nxt = '0;
        bx_nxt = '0;
        if (({1'b0, row_r} + pcds_pkg::DIM_W'(1)) >= h_eff) begin
          row_nxt = '0;
          cy_nxt = '0;
          by_nxt = '0;
        end else begin
          row_nxt = row_r + pcds_pkg::POS_W'(1);
          if ({1'b0, cy_r} == sym1) begin
            cy_nxt = '0;
            by_nxt = by_r + pcds_pkg::BLK_W'(1);
          end else begin
            cy_nxt = cy_r + pcds_pkg::PH_W'(1);
          end
        end
      end else begin
        col_nxt = col_r + pcds_pkg::POS_W'(1);
        if ({1'b0, cx_r} == sxm1) begin
          cx_nxt = '0;
          bx_nxt = bx_r + pcds_pkg::BLK_W'(1);
        end else begin
          cx_nxt = cx_r + pcds_pkg::PH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
      bx_r <= '0;
      by_r <= '0;
      nbx_r <= '0;
      nby_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      bx_r <= bx_nxt;
      by_r <= by_nxt;
      nbx_r <= nbx_nxt;
      nby_r <= nby_nxt;
    end
  end

  // Corner classification of the incoming point.
  always_comb begin
    cx_first = (cx_r == '0);
    cx_last = ({1'b0, cx_r} == sxm1);
    cy_first = (cy_r == '0);
    cy_last = ({1'b0, cy_r} == sym1);
    in_grid = ({1'b0, bx_r} < nbx_r) && ({1'b0, by_r} < nby_r);
    hit = (cx_first || cx_last) && (cy_first || cy_last) && in_grid;
    flast = ((pcds_pkg::NBLK_W'(bx_r) + pcds_pkg::NBLK_W'(1)) == nbx_r) &&
            ((pcds_pkg::NBLK_W'(by_r) + pcds_pkg::NBLK_W'(1)) == nby_r);
    pt.sum_x = pcds_pkg::SUM_W'(in_x_in);
    pt.sum_y = pcds_pkg::SUM_W'(in_y_in);
    pt.sum_z = pcds_pkg::SUM_W'(in_z_in);
    pt.csum = {2'b00, in_chan2_in, 2'b00, in_chan1_in, 2'b00, in_chan0_in};
    pt.ok = {in_z_ok, in_y_ok, in_x_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc && hit;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= cx_first && cy_first;
    s1_last_r <= cx_last && cy_last;
    s1_flast_r <= flast;
    s1_addr_r <= bx_r;
    s1_pt_r <= pt;
  end

  pcds_ram #(
    .WIDTH(pcds_pkg::ENTRY_W),
    .DEPTH(pcds_pkg::MAX_BLOCKS_PER_ROW)
  ) u_sum_ram (
    .clk(clk),
    .we(s1_vld_r),
    .waddr(s1_addr_r),
    .wdata(upd),
    .re(in_acc),
    .raddr(bx_r),
    .rdata(ram_rdata)
  );

  // Read-modify-write of the block entry, with the previous write forwarded.
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == s1_addr_r)) begin
      base = fwd_data_r;
    end else begin
      base = pcds_pkg::entry_t'(ram_rdata);
    end
    if (s1_first_r) begin
      upd = s1_pt_r;
    end else begin
      upd.sum_x = base.sum_x + s1_pt_r.sum_x;
      upd.sum_y = base.sum_y + s1_pt_r.sum_y;
      upd.sum_z = base.sum_z + s1_pt_r.sum_z;
      upd.csum = base.csum + s1_pt_r.csum;
      upd.ok = base.ok & s1_pt_r.ok;
    end
    res.x_avg = upd.ok[0] ? upd.sum_x[pcds_pkg::SUM_W-1:2] : '0;
    res.y_avg = upd.ok[1] ? upd.sum_y[pcds_pkg::SUM_W-1:2] : '0;
    res.z_avg = upd.ok[2] ? upd.sum_z[pcds_pkg::SUM_W-1:2] : '0;
    res.ok = upd.ok;
    res.chan0_avg = upd.csum[pcds_pkg::CFIELD_W-1:2];
    res.chan1_avg = upd.csum[2*pcds_pkg::CFIELD_W-1:pcds_pkg::CFIELD_W+2];
    res.chan2_avg = upd.csum[3*pcds_pkg::CFIELD_W-1:2*pcds_pkg::CFIELD_W+2];
    res.frame_last = s1_flast_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else begin
      fwd_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= upd;
  end

  // Output register and skid entry.
  always_comb begin
    s1_res = s1_vld_r && s1_last_r;
    out_free = !out_vld_r || !out_stall;
    out_vld_nxt = out_vld_r && out_stall;
    skid_vld_nxt = skid_vld_r;
    out_ld_skid = 1'b0;
    out_ld_s1 = 1'b0;
    skid_ld = 1'b0;
    priority if (skid_vld_r) begin
      if (out_free) begin
        out_ld_skid = 1'b1;
        out_vld_nxt = 1'b1;
        skid_vld_nxt = 1'b0;
      end
    end else if (s1_res) begin
      if (out_free) begin
        out_ld_s1 = 1'b1;
        out_vld_nxt = 1'b1;
      end else begin
        skid_ld = 1'b1;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld_skid) begin
      out_r <= skid_r;
    end else if (out_ld_s1) begin
      out_r <= res;
    end
    if (skid_ld) begin
      skid_r <= res;
    end
  end

  assign in_stall = (state_r != pcds_pkg::ST_IDLE) || skid_vld_r || (out_vld_r && out_stall);

  assign out_valid = out_vld_r;
  assign out_x_avg = out_r.x_avg;
  assign out_y_avg = out_r.y_avg;
  assign out_z_avg = out_r.z_avg;
  assign out_x_avg_ok = out_r.ok[0];
  assign out_y_avg_ok = out_r.ok[1];
  assign out_z_avg_ok = out_r.ok[2];
  assign out_chan0_avg = out_r.chan0_avg;
  assign out_chan1_avg = out_r.chan1_avg;
  assign out_chan2_avg = out_r.chan2_avg;
  assign out_frame_last = out_r.frame_last;

  // The skid entry is only ever occupied behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry valid while output register empty");

  // A point in the read-modify-write stage cannot coexist with a parked result.
  a_skid_excl_s1: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> !s1_vld_r)
    else $error("skid entry valid while a block update is in flight");

  a_skid_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && out_stall))
    else $error("skid entry filled without a stalled output");

  // Once the geometry is settled, the in-block phases stay below the strides.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcds_pkg::ST_IDLE) |-> (({1'b0, cx_r} <= sxm1) && ({1'b0, cy_r} <= sym1)))
    else $error("block phase counter out of range");

endmodule
`default_nettype wire

FILE: src/pcds_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module pcds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: src/pcds_div.sv
// Iterative shift-subtract divider of size or position by stride, one bit per cycle on step.
`default_nettype none
module pcds_div (
  input  wire logic                         clk,
  input  wire logic                         load,
  input  wire logic                         step,
  input  wire logic [pcds_pkg::DIM_W-1:0]   dividend,
  input  wire logic [pcds_pkg::STR_W-1:0]   divisor,
  output logic      [pcds_pkg::DIM_W-1:0]   quot,
  output logic      [pcds_pkg::PH_W-1:0]    rem
);

  logic [pcds_pkg::DIM_W-1:0] q_r, q_nxt;
  logic [pcds_pkg::PH_W-1:0]  rem_r, rem_nxt;
  logic [pcds_pkg::STR_W-1:0] d_r;
  logic [pcds_pkg::PH_W:0]    trial;
  logic [pcds_pkg::PH_W:0]    diff;
  logic                       ge;

  always_comb begin
    trial = {rem_r, q_r[pcds_pkg::DIM_W-1]};
    ge = (trial >= d_r);
    diff = trial - d_r;
    rem_nxt = ge ? diff[pcds_pkg::PH_W-1:0] : trial[pcds_pkg::PH_W-1:0];
    q_nxt = {q_r[pcds_pkg::DIM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= dividend;
      rem_r <= '0;
      d_r <= divisor;
    end else if (step) begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = q_r;
  assign rem = rem_r;

endmodule
`default_nettype wire
